### rtl/core/factorization_machine_score_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the FM scoring block
// Clocked concurrent checks, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FACTORIZATION_MACHINE_SCORE_MACROS_SVH
`define FACTORIZATION_MACHINE_SCORE_MACROS_SVH

`ifndef SYNTHESIS
// check outside reset
`define FMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check at every edge, reset included
`define FMS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FMS_ASSERT(lbl, prop, msg)
`define FMS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/core/fms_pkg.sv
// ---------------------------------------------------------------------------
// fms_pkg
// Shared constants and types of the FM scoring block.
// ---------------------------------------------------------------------------
package fms_pkg;

  localparam int FMS_FACTORS     = 8;   // default factor count
  localparam int FMS_MAX_FACTORS = 8;   // factor lanes carried per item
  localparam int FMS_QDEPTH      = 4;   // work queue depth
  localparam int FMS_QCW         = $clog2(FMS_QDEPTH + 1);
  localparam int FMS_TW          = 100; // score accumulator, Q52.48 x2

  localparam logic [30:0] FMS_LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] FMS_LN2_Q32   = 32'd2977044472;
  localparam logic [20:0] FMS_A_LIMIT   = 21'h100000;     // 16.0 in Q8.16
  localparam logic [3:0]  FMS_TERMS     = 4'd12;
  localparam logic [5:0]  FMS_PDIV_LAST = 6'd49;          // 50 quotient bits
  localparam logic [5:0]  FMS_KDIV_LAST = 6'd8;           // 9 x 4 bits

  // one feature after the multipliers
  typedef struct packed {
    logic                              last;
    logic [FMS_MAX_FACTORS-1:0][63:0] sq;
    logic [FMS_MAX_FACTORS-1:0][31:0] d;
    logic [31:0]                       lin;
  } fms_work_t;

  typedef struct packed {
    logic               empty;
    logic [FMS_QCW-1:0] count;
  } fms_qstat_t;

endpackage

### rtl/core/fms_intf.sv
// ---------------------------------------------------------------------------
// fms_intf
// Valid/ready channels for feature items and score items.
// ---------------------------------------------------------------------------
interface fms_feat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] feature_value;
  logic signed [15:0] linear_weight;
  logic signed [15:0] factor_0;
  logic signed [15:0] factor_1;
  logic signed [15:0] factor_2;
  logic signed [15:0] factor_3;
  logic signed [15:0] factor_4;
  logic signed [15:0] factor_5;
  logic signed [15:0] factor_6;
  logic signed [15:0] factor_7;
  logic               last_feature;

  modport source (output valid, feature_value, linear_weight, factor_0, factor_1,
                  factor_2, factor_3, factor_4, factor_5, factor_6, factor_7,
                  last_feature, input ready);
  modport sink   (input valid, feature_value, linear_weight, factor_0, factor_1,
                  factor_2, factor_3, factor_4, factor_5, factor_6, factor_7,
                  last_feature, output ready);
endinterface

interface fms_score_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] logit;
  logic        [15:0] probability;

  modport source (output valid, logit, probability, input ready);
  modport sink   (input valid, logit, probability, output ready);
endinterface

### rtl/core/fms_front.sv
// ---------------------------------------------------------------------------
// fms_front
// Takes feature items, forms weight*value products and squares, feeds queue.
// ---------------------------------------------------------------------------
module fms_front
  import fms_pkg::*;
#(
  parameter int FACTORS = FMS_FACTORS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fms_feat_if.sink   feat_i,
  input  fms_qstat_t qstat_i,
  output logic       push_o,
  output fms_work_t  work_o
);

  logic signed [15:0] fac [FMS_MAX_FACTORS];
  logic [FMS_QCW:0]   occ;
  logic               take;

  logic               v1_q, v2_q;
  logic               last1_q, last2_q;
  logic signed [31:0] lin1_q, lin2_q;
  logic signed [31:0] d1_q [FMS_MAX_FACTORS];
  logic signed [31:0] d2_q [FMS_MAX_FACTORS];
  logic signed [63:0] sq2_q [FMS_MAX_FACTORS];

  assign fac[0] = feat_i.factor_0;
  assign fac[1] = feat_i.factor_1;
  assign fac[2] = feat_i.factor_2;
  assign fac[3] = feat_i.factor_3;
  assign fac[4] = feat_i.factor_4;
  assign fac[5] = feat_i.factor_5;
  assign fac[6] = feat_i.factor_6;
  assign fac[7] = feat_i.factor_7;

  // credit: queue entries plus items still in the two stages
  assign occ = {1'b0, qstat_i.count} + (FMS_QCW+1)'(v1_q) + (FMS_QCW+1)'(v2_q);
  assign feat_i.ready = occ < (FMS_QCW+1)'(FMS_QDEPTH);
  assign take = feat_i.valid && feat_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= take;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lin1_q  <= feat_i.linear_weight * feat_i.feature_value;
    last1_q <= feat_i.last_feature;
    for (int f = 0; f < FMS_MAX_FACTORS; f++) begin
      d1_q[f] <= (f < FACTORS) ? fac[f] * feat_i.feature_value : 32'sd0;
    end
    lin2_q  <= lin1_q;
    last2_q <= last1_q;
    for (int f = 0; f < FMS_MAX_FACTORS; f++) begin
      d2_q[f]  <= d1_q[f];
      sq2_q[f] <= d1_q[f] * d1_q[f];
    end
  end

  assign push_o = v2_q;

  always_comb begin
    work_o.lin  = lin2_q;
    work_o.last = last2_q;
    for (int f = 0; f < FMS_MAX_FACTORS; f++) begin
      work_o.d[f]  = d2_q[f];
      work_o.sq[f] = sq2_q[f];
    end
  end

endmodule

### rtl/core/fms_queue.sv
// ---------------------------------------------------------------------------
// fms_queue
// Short FIFO between the multiplier front and the accumulate back.
// ---------------------------------------------------------------------------
module fms_queue
  import fms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fms_work_t  data_i,
  input  logic       pop_i,
  output fms_work_t  head_o,
  output fms_qstat_t qstat_o
);

  localparam int PW = (FMS_QDEPTH > 1) ? $clog2(FMS_QDEPTH) : 1;

  fms_work_t          mem_q [FMS_QDEPTH];
  logic [PW-1:0]      wr_q, rd_q;
  logic [FMS_QCW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(FMS_QDEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(FMS_QDEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FMS_QCW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FMS_QCW'(1);
      end
    end
  end

  assign head_o        = mem_q[rd_q];
  assign qstat_o.count = count_q;
  assign qstat_o.empty = (count_q == '0);

endmodule

### rtl/core/fms_back.sv
// ---------------------------------------------------------------------------
// fms_back
// Accumulates queued features; on the last one forms logit and probability.
// ---------------------------------------------------------------------------
module fms_back
  import fms_pkg::*;
#(
  parameter int FACTORS = FMS_FACTORS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fms_qstat_t         qstat_i,
  input  fms_work_t          head_i,
  output logic               pop_o,
  input  logic signed [15:0] bias_i,
  fms_score_if.source        score_o
);

`include "factorization_machine_score_macros.svh"

  localparam int FW = (FACTORS > 1) ? $clog2(FACTORS) : 1;
  localparam int TW = FMS_TW;

  typedef enum logic [3:0] {
    S_ACC, S_INIT, S_ABS, S_MUL, S_ADD, S_RND, S_LA, S_LY,
    S_LZ, S_TM, S_DV, S_EXP, S_PD, S_OUT
  } state_e;

  state_e             state_q;
  logic signed [47:0] lin_q;
  logic signed [47:0] fsum_q [FACTORS];
  logic        [63:0] fsq_q  [FACTORS];
  logic [FW-1:0]      f_q;
  logic [1:0]         ph_q;
  logic [47:0]        mag_q, prod_q;
  logic signed [TW-1:0] t_q;
  logic signed [31:0] logit_q;
  logic [20:0]        a_q;
  logic [51:0]        y_q;
  logic [4:0]         n_q;
  logic [31:0]        z_q;
  logic [3:0]         k_q;
  logic [32:0]        term_q;
  logic signed [34:0] sum_q;
  logic [35:0]        dq_q;
  logic [3:0]         rem_q;
  logic [5:0]         cnt_q;
  logic [49:0]        pn_q;
  logic [34:0]        pr_q, den_q;
  logic               vld_q;
  logic signed [31:0] ologit_q;
  logic [15:0]        oprob_q;

  logic signed [TW-1:0] rnd;
  logic                 fits;
  logic [31:0]          sat;
  logic [32:0]          lmag;
  logic [63:0]          zp;
  logic [64:0]          tz;
  logic [39:0]          kd;
  logic [32:0]          e_c;
  logic [35:0]          pr_try;
  logic signed [47:0]   sel;
  logic                 load;

  // four restoring quotient bits per call, divisor is the term index
  function automatic logic [39:0] kdiv4(input logic [35:0] dq, input logic [3:0] rem,
                                        input logic [3:0] k);
    logic [4:0]  r5;
    logic [35:0] d;
    logic [3:0]  r;
    d = dq;
    r = rem;
    for (int i = 0; i < 4; i++) begin
      r5 = {r, d[35]};
      d  = {d[34:0], 1'b0};
      if (r5 >= {1'b0, k}) begin
        r5   = r5 - {1'b0, k};
        d[0] = 1'b1;
      end
      r = r5[3:0];
    end
    return {r, d};
  endfunction

  assign rnd  = $signed(t_q + (TW'(1) << 32)) >>> 33;
  assign fits = (&rnd[TW-1:31]) || (~|rnd[TW-1:31]);
  assign sat  = fits ? rnd[31:0] : (rnd[TW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  assign lmag = logit_q[31] ? (33'd0 - {1'b1, logit_q}) : {1'b0, logit_q};
  assign zp   = 64'(y_q[45:14]) * 64'(FMS_LN2_Q32);
  assign tz   = 65'(term_q) * 65'(z_q);
  assign kd   = kdiv4(dq_q, rem_q, k_q);
  assign e_c  = 33'($unsigned(sum_q) >> n_q);
  assign pr_try = {pr_q, pn_q[49]};
  assign sel  = fsum_q[f_q];

  assign pop_o = (state_q == S_ACC) && !qstat_i.empty;
  assign load  = (state_q == S_OUT) && (!vld_q || score_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      vld_q   <= 1'b0;
      lin_q   <= '0;
      for (int f = 0; f < FACTORS; f++) begin
        fsum_q[f] <= '0;
        fsq_q[f]  <= '0;
      end
    end else begin
      if (load) begin
        vld_q <= 1'b1;
      end else if (score_o.ready) begin
        vld_q <= 1'b0;
      end
      unique case (state_q)
        S_ACC: begin
          if (pop_o) begin
            lin_q <= lin_q + {{16{head_i.lin[31]}}, head_i.lin};
            for (int f = 0; f < FACTORS; f++) begin
              fsum_q[f] <= fsum_q[f] + {{16{head_i.d[f][31]}}, head_i.d[f]};
              fsq_q[f]  <= fsq_q[f] + head_i.sq[f];
            end
            if (head_i.last) begin
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          t_q <= ({{(TW-16){bias_i[15]}}, bias_i} << 37)
               + ({{(TW-48){lin_q[47]}}, lin_q} << 25);
          f_q     <= '0;
          ph_q    <= 2'd0;
          state_q <= S_ABS;
        end
        S_ABS: begin
          mag_q   <= sel[47] ? (48'd0 - sel) : sel;
          state_q <= S_MUL;
        end
        S_MUL: begin
          // square of |s| from 24-bit halves
          case (ph_q)
            2'd0:    prod_q <= 48'(mag_q[47:24]) * 48'(mag_q[47:24]);
            2'd1:    prod_q <= 48'(mag_q[47:24]) * 48'(mag_q[23:0]);
            default: prod_q <= 48'(mag_q[23:0]) * 48'(mag_q[23:0]);
          endcase
          state_q <= S_ADD;
        end
        S_ADD: begin
          case (ph_q)
            2'd0:    t_q <= t_q + (TW'(prod_q) << 48);
            2'd1:    t_q <= t_q + (TW'(prod_q) << 25);
            2'd2:    t_q <= t_q + TW'(prod_q);
            default: t_q <= t_q - TW'(fsq_q[f_q]);
          endcase
          if (ph_q == 2'd3) begin
            ph_q <= 2'd0;
            if (f_q == FW'(FACTORS - 1)) begin
              state_q <= S_RND;
            end else begin
              f_q     <= f_q + FW'(1);
              state_q <= S_ABS;
            end
          end else begin
            ph_q    <= ph_q + 2'd1;
            state_q <= (ph_q == 2'd2) ? S_ADD : S_MUL;
          end
        end
        S_RND: begin
          logit_q <= sat;
          state_q <= S_LA;
        end
        S_LA: begin
          a_q     <= (lmag > 33'(FMS_A_LIMIT)) ? FMS_A_LIMIT : lmag[20:0];
          state_q <= S_LY;
        end
        S_LY: begin
          y_q     <= 52'(a_q) * 52'(FMS_LOG2E_Q30);
          state_q <= S_LZ;
        end
        S_LZ: begin
          z_q     <= zp[63:32];
          n_q     <= y_q[50:46];
          term_q  <= 33'h1_0000_0000;
          sum_q   <= 35'sh1_0000_0000;
          k_q     <= 4'd1;
          state_q <= S_TM;
        end
        S_TM: begin
          dq_q    <= {3'b000, tz[64:32]};
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DV;
        end
        S_DV: begin
          rem_q <= kd[39:36];
          dq_q  <= kd[35:0];
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == FMS_KDIV_LAST) begin
            term_q <= kd[32:0];
            sum_q  <= k_q[0] ? sum_q - $signed({2'b00, kd[32:0]})
                             : sum_q + $signed({2'b00, kd[32:0]});
            if (k_q == FMS_TERMS) begin
              state_q <= S_EXP;
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= S_TM;
            end
          end
        end
        S_EXP: begin
          // p = (2e*65536 + d) / 2d with d = 2^32 + e
          pn_q    <= ({17'd0, e_c} << 17) + 50'h1_0000_0000 + 50'(e_c);
          den_q   <= {(34'h1_0000_0000 + 34'(e_c)), 1'b0};
          pr_q    <= '0;
          cnt_q   <= '0;
          state_q <= S_PD;
        end
        S_PD: begin
          if (pr_try >= {1'b0, den_q}) begin
            pr_q <= 35'(pr_try - {1'b0, den_q});
            pn_q <= {pn_q[48:0], 1'b1};
          end else begin
            pr_q <= pr_try[34:0];
            pn_q <= {pn_q[48:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == FMS_PDIV_LAST) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (load) begin
            ologit_q <= logit_q;
            if (logit_q[31]) begin
              oprob_q <= pn_q[15:0];
            end else if (pn_q[16:0] == 17'd0) begin
              oprob_q <= 16'hFFFF;
            end else begin
              oprob_q <= 16'(17'h10000 - pn_q[16:0]);
            end
            lin_q <= '0;
            for (int f = 0; f < FACTORS; f++) begin
              fsum_q[f] <= '0;
              fsq_q[f]  <= '0;
            end
            state_q <= S_ACC;
          end
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

  assign score_o.valid       = vld_q;
  assign score_o.logit       = ologit_q;
  assign score_o.probability = oprob_q;

  `FMS_ASSERT(a_clear_after_load, load |=> (lin_q == '0 && state_q == S_ACC), "accumulators not cleared")
  `FMS_ASSERT(a_pdiv_bound, (state_q == S_PD) |-> (cnt_q <= FMS_PDIV_LAST), "divider overran")
  `FMS_ASSERT(a_neg_prob, (vld_q && ologit_q[31]) |-> (oprob_q <= 16'd32768), "negative logit prob above half")
  `FMS_ASSERT_RST(a_rst_idle, !rst_ni |=> (!vld_q && state_q == S_ACC), "not idle in reset")

endmodule

### rtl/core/factorization_machine_score.sv
// ---------------------------------------------------------------------------
// factorization_machine_score
// Second-order factorization machine scoring of one sparse sample.
// ---------------------------------------------------------------------------
// Usage:
//  - feat_i carries one active feature per item: value, linear weight and
//    eight latent weights (Q4.12); last_feature closes the sample.
//  - score_o carries one item per sample: logit (Q16.16, saturated) and its
//    logistic (Q0.16, rounded).
//  - cfg_we_i/cfg_wdata_i write the bias (Q4.12); write only while idle.
//  - Features stream at one item per cycle while the queue has room:
//    products and squares are formed in a two-stage front, a 4-entry
//    queue then feeds the accumulators.
//  - After the last feature the back end squares each factor sum from
//    split 48-bit halves, sums a 12-term series (a radix-16 divide by the
//    term index per term) and runs a bit-serial probability divide. Input
//    items keep filling the queue meanwhile and stall once it is full.
//  - A finished score sits in the output register; if score_o stalls, the
//    next sample accumulates and waits only for the register to free up.
//  - Reset clears the bias, accumulators, queue and output valid.
// ---------------------------------------------------------------------------
module factorization_machine_score
  import fms_pkg::*;
#(
  parameter int FACTORS = FMS_FACTORS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fms_feat_if.sink           feat_i,
  fms_score_if.source        score_o,
  input  logic               cfg_we_i,
  input  logic signed [15:0] cfg_wdata_i
);

  logic signed [15:0] bias_q;
  logic               push;
  logic               pop;
  fms_work_t          work;
  fms_work_t          head;
  fms_qstat_t         qstat;

  // bias register, single config word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
    end else if (cfg_we_i) begin
      bias_q <= cfg_wdata_i;
    end
  end

  // front: accept and multiply
  fms_front #(.FACTORS(FACTORS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .feat_i  (feat_i),
    .qstat_i (qstat),
    .push_o  (push),
    .work_o  (work)
  );

  // decoupling queue
  fms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // back: accumulate and score
  fms_back #(.FACTORS(FACTORS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .head_i  (head),
    .pop_o   (pop),
    .bias_i  (bias_q),
    .score_o (score_o)
  );

endmodule

### sim/factorization_machine_score_tb.sv
// ---------------------------------------------------------------------------
// factorization_machine_score_tb
// Streams feature items through the FM scorer and checks each score item
// against a local bit-exact scoring model. A directed table comes first, then
// random samples under several bias settings. Both sides stall at random.
// ---------------------------------------------------------------------------
module factorization_machine_score_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fms_pkg::*;

  localparam int  N_ITEMS     = 1700;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  SETTLE      = 400;
  localparam int  IDLE_PCT    = 37;

  typedef struct {
    logic signed [15:0] value;
    logic signed [15:0] weight;
    logic signed [15:0] fac [8];
    logic               last;
  } feature_t;

  typedef struct {
    logic signed [31:0] logit;
    logic        [15:0] prob;
  } score_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic signed [15:0] cfg_wdata_i = '0;

  fms_feat_if  feat_if ();
  fms_score_if score_if ();

  factorization_machine_score u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .feat_i      (feat_if),
    .score_o     (score_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // scoring model state
  logic signed [15:0] bias_q;
  logic [47:0]        lin_acc;
  logic [47:0]        fsum [8];
  logic [63:0]        fsq  [8];

  score_t score_q [$];       // scores still owed by the block
  int     n_errors   = 0;
  int     n_accepted = 0;
  bit     no_idle    = 1'b0; // stretch with both sides always ready
  bit     held       = 1'b0; // sender hold-off already done
  int     cycles     = 0;

  // logistic of a Q16.16 logit, Q0.16 rounded
  function automatic logic [15:0] logistic_q16(logic signed [31:0] logit);
    longint unsigned a, y, n, fq, z, term, e, d, p;
    longint          acc;
    a = (logit < 0) ? longint'(-longint'(logit)) : longint'(logit);
    if (a > 64'(FMS_A_LIMIT)) a = 64'(FMS_A_LIMIT);
    y    = a * 64'(FMS_LOG2E_Q30);
    n    = y >> 46;
    fq   = (y & ((64'd1 << 46) - 1)) >> 14;
    z    = (fq * 64'(FMS_LN2_Q32)) >> 32;
    acc  = 64'sd1 <<< 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * z) >> 32) / k;
      if (k % 2) acc -= longint'(term);
      else       acc += longint'(term);
    end
    e = longint'(acc) >> n;
    d = (64'd1 << 32) + e;
    p = (2 * e * 65536 + d) / (2 * d);
    if (logit < 0) return p[15:0];
    p = 65536 - p;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  // fold one feature into the sums; returns 1 with the score on a last item
  function automatic bit score_feature(feature_t it, output score_t sc);
    logic signed [31:0]  prod;
    logic signed [127:0] s, t, r;
    prod    = it.weight * it.value;
    lin_acc = lin_acc + {{16{prod[31]}}, prod};
    for (int f = 0; f < FMS_FACTORS; f++) begin
      prod    = it.fac[f] * it.value;
      fsum[f] = fsum[f] + {{16{prod[31]}}, prod};
      fsq[f]  = fsq[f] + 64'(longint'(prod) * longint'(prod));
    end
    if (!it.last) return 1'b0;
    // score times two in Q80.48, so the one half stays exact
    t = ({{112{bias_q[15]}}, bias_q} << 37) + ({{80{lin_acc[47]}}, lin_acc} << 25);
    for (int f = 0; f < FMS_FACTORS; f++) begin
      s = {{80{fsum[f][47]}}, fsum[f]};
      t = t + s * s - {64'd0, fsq[f]};
    end
    r = (t + (128'sd1 <<< 32)) >>> 33;
    if (r > 128'sh7FFFFFFF)        sc.logit = 32'sh7FFFFFFF;
    else if (r < -128'sh80000000)  sc.logit = 32'sh80000000;
    else                           sc.logit = r[31:0];
    sc.prob = logistic_q16(sc.logit);
    lin_acc = '0;
    for (int f = 0; f < 8; f++) begin
      fsum[f] = '0;
      fsq[f]  = '0;
    end
    return 1'b1;
  endfunction

  function automatic feature_t make_feature(logic signed [15:0] v, logic signed [15:0] w,
                                            logic signed [15:0] fv, logic l);
    feature_t it;
    it.value  = v;
    it.weight = w;
    for (int f = 0; f < 8; f++) it.fac[f] = fv;
    it.last = l;
    return it;
  endfunction

  // random field: extremes, small values or full range
  function automatic logic signed [15:0] rand_field(int mag);
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3, 4:    return 16'($signed($urandom_range(2 * mag)) - mag);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic feature_t rand_feature(int mag, logic l);
    feature_t it;
    it.value  = rand_field(mag);
    it.weight = rand_field(mag);
    for (int f = 0; f < 8; f++) it.fac[f] = rand_field(mag);
    it.last = l;
    return it;
  endfunction

  // drive one item from a rising edge and hold it until taken
  task automatic send_feature(feature_t it);
    score_t sc;
    // idle at random before each item, so about IDLE_PCT of the cycles stay empty
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      feat_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    feat_if.valid         <= 1'b1;
    feat_if.feature_value <= it.value;
    feat_if.linear_weight <= it.weight;
    feat_if.factor_0      <= it.fac[0];
    feat_if.factor_1      <= it.fac[1];
    feat_if.factor_2      <= it.fac[2];
    feat_if.factor_3      <= it.fac[3];
    feat_if.factor_4      <= it.fac[4];
    feat_if.factor_5      <= it.fac[5];
    feat_if.factor_6      <= it.fac[6];
    feat_if.factor_7      <= it.fac[7];
    feat_if.last_feature  <= it.last;
    do @(posedge clk_i); while (!feat_if.ready);
    n_accepted++;
    if (score_feature(it, sc)) score_q.push_back(sc);
  endtask

  // wait for every owed score, then let the back end settle
  task automatic drain();
    feat_if.valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_bias(logic signed [15:0] b);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bias_q = b;
  endtask

  // score side: random stalls, compare each taken item with the oldest owed one
  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni && score_if.valid && score_if.ready) begin
      if (score_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected score logit=%0d prob=%0d",
                   score_if.logit, score_if.probability);
      end else begin
        want = score_q.pop_front();
        if (score_if.logit !== want.logit || score_if.probability !== want.prob) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: score mismatch: logit exp %0d got %0d, prob exp %0d got %0d",
                     want.logit, score_if.logit, want.prob, score_if.probability);
        end
      end
    end
    score_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    feature_t dir_tab [20];
    bit       dir_chk [20];   // row carries a typed expectation
    score_t   dir_exp [20];
    logic signed [15:0] bias_set [5];
    int       len, mag;

    feat_if.valid = 1'b0;
    feat_if.feature_value = '0;
    feat_if.linear_weight = '0;
    feat_if.factor_0 = '0;
    feat_if.factor_1 = '0;
    feat_if.factor_2 = '0;
    feat_if.factor_3 = '0;
    feat_if.factor_4 = '0;
    feat_if.factor_5 = '0;
    feat_if.factor_6 = '0;
    feat_if.factor_7 = '0;
    feat_if.last_feature = 1'b0;
    score_if.ready = 1'b0;
    bias_q  = '0;
    lin_acc = '0;
    for (int f = 0; f < 8; f++) begin
      fsum[f] = '0;
      fsq[f]  = '0;
    end

    // directed table
    dir_chk = '{default: 1'b0};
    dir_tab[0] = make_feature(16'sh0000, 16'sh0000, 16'sh0000, 1'b1); // empty score
    dir_chk[0] = 1'b1;
    dir_exp[0].logit = 32'sd0;
    dir_exp[0].prob  = 16'd32768;                                     // logistic(0)
    dir_tab[1] = make_feature(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1); // single max
    dir_tab[2] = make_feature(16'sh8000, 16'sh8000, 16'sh8000, 1'b1); // single min
    dir_tab[3] = make_feature(16'sh8000, 16'sh7FFF, 16'sh0000, 1'b1); // linear only
    // eight min features: pairwise term saturates high
    for (int i = 4; i < 12; i++)
      dir_tab[i] = make_feature(16'sh8000, 16'sh0000, 16'sh8000, i == 11);
    // alternating factor signs: cross terms drive the score low
    for (int i = 12; i < 19; i++)
      dir_tab[i] = make_feature(16'sh8000, 16'sh8000, (i % 2) ? 16'sh7FFF : 16'sh8000,
                                1'b0);
    dir_tab[19] = make_feature(16'sh1000, 16'sh0F00, 16'shF000, 1'b1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_feature(dir_tab[i]);
      // typed rows replace the model's expectation with the known answer
      if (dir_chk[i]) begin
        void'(score_q.pop_back());
        score_q.push_back(dir_exp[i]);
      end
    end
    drain();

    // bias phases: extremes first, then zero, a random value and one
    bias_set = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'($urandom), 16'sh0001};
    foreach (bias_set[p]) begin
      write_bias(bias_set[p]);
      if (p == 0) begin
        // bias alone on two empty samples
        send_feature(make_feature(16'sh0000, 16'sh0000, 16'sh0000, 1'b1));
        send_feature(make_feature(16'sh0000, 16'sh0000, 16'sh0000, 1'b1));
      end
      while (n_accepted < (p + 1) * N_ITEMS / 5) begin
        no_idle = (n_accepted > 600 && n_accepted < 800);
        // one hold-off until the block has caught up
        if (!held && n_accepted > 1000) begin
          held = 1'b1;
          feat_if.valid <= 1'b0;
          while (score_q.size() != 0) @(posedge clk_i);
        end
        // mostly short samples, now and then a long one of small magnitude
        if ($urandom_range(49) == 0) begin
          len = $urandom_range(40, 256);
          mag = 256;
        end else begin
          len = $urandom_range(1, 8);
          mag = $urandom_range(1) ? 4096 : 32767;
        end
        for (int i = 0; i < len; i++) send_feature(rand_feature(mag, i == len - 1));
      end
      drain();
    end
    no_idle = 1'b0;

    if (n_errors == 0 && score_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/fms_pkg.sv
rtl/core/fms_intf.sv
rtl/core/fms_front.sv
rtl/core/fms_queue.sv
rtl/core/fms_back.sv
rtl/core/factorization_machine_score.sv
sim/factorization_machine_score_tb.sv
